>>> rtl/core/acal_pkg.sv
// Shared types and constants for the axis auto-calibration block.
// No dependencies; imported by every module under rtl/core.
package acal_pkg;

    localparam int AXIS_COUNT_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int APB_AW          = 4;

    localparam logic [14:0] REST_RESET   = 15'd4096;
    localparam logic [15:0] THRESH_RESET = 16'd3277;
    localparam logic [15:0] TRAVEL_RESET = 16'd16384;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_CAPTURE = 3'd1,
        OP_OBSERVE = 3'd2,
        OP_APPLY   = 3'd3,
        OP_LOAD    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_REST   = 2'd1,
        REG_THRESH = 2'd2,
        REG_TRAVEL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        mode;
        logic [14:0] max_rest;
        logic [15:0] thresh;
        logic [15:0] min_travel;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic we_center;
        logic we_limits;
        logic we_conn;
        logic we_moved;
        logic moved;
    } st_wr_t;

endpackage

>>> rtl/core/acal_cfg.sv
// APB register file for the calibration settings.
// Depends on acal_pkg for the register index codes and the cfg_t bundle.
module acal_cfg
    import acal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t sel;

    assign sel    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= 1'b0;
            cfg_reg.max_rest   <= REST_RESET;
            cfg_reg.thresh     <= THRESH_RESET;
            cfg_reg.min_travel <= TRAVEL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (sel)
                REG_MODE:   cfg_reg.mode       <= pwdata[0];
                REG_REST:   cfg_reg.max_rest   <= pwdata[14:0];
                REG_THRESH: cfg_reg.thresh     <= pwdata[15:0];
                REG_TRAVEL: cfg_reg.min_travel <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_MODE:   prdata = 32'(cfg_reg.mode);
            REG_REST:   prdata = 32'(cfg_reg.max_rest);
            REG_THRESH: prdata = 32'(cfg_reg.thresh);
            REG_TRAVEL: prdata = 32'(cfg_reg.min_travel);
            default:    prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/acal_store.sv
// Per-axis calibration state: center, limits, connect reading, moved flag.
// Depends on acal_pkg for the st_wr_t write command.
module acal_store
    import acal_pkg::*;
#(
    parameter int AXIS_COUNT  = AXIS_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [2:0]                    idx,
    input  st_wr_t                        wr,
    input  logic signed [SAMPLE_BITS-1:0] wr_center,
    input  logic signed [SAMPLE_BITS-1:0] wr_min,
    input  logic signed [SAMPLE_BITS-1:0] wr_max,
    input  logic signed [SAMPLE_BITS-1:0] wr_conn,
    output logic signed [SAMPLE_BITS-1:0] rd_center,
    output logic signed [SAMPLE_BITS-1:0] rd_min,
    output logic signed [SAMPLE_BITS-1:0] rd_max,
    output logic signed [SAMPLE_BITS-1:0] rd_conn,
    output logic                          rd_moved
);

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    logic signed [SAMPLE_BITS-1:0] center_reg [AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] min_reg    [AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] max_reg    [AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] conn_reg   [AXIS_COUNT];
    logic [AXIS_COUNT-1:0]         moved_reg;

    logic          in_range;
    logic [AW-1:0] ai;

    assign in_range = (32'(idx) < 32'(AXIS_COUNT));
    assign ai       = AW'(idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                center_reg[i] <= '0;
                min_reg[i]    <= '0;
                max_reg[i]    <= '0;
                conn_reg[i]   <= '0;
            end
            moved_reg <= '0;
        end
        else if (wr.clear)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                center_reg[i] <= '0;
                min_reg[i]    <= '0;
                max_reg[i]    <= '0;
                conn_reg[i]   <= '0;
            end
            moved_reg <= '0;
        end
        else if (in_range)
        begin
            if (wr.we_center)
                center_reg[ai] <= wr_center;
            if (wr.we_limits)
            begin
                min_reg[ai] <= wr_min;
                max_reg[ai] <= wr_max;
            end
            if (wr.we_conn)
                conn_reg[ai] <= wr_conn;
            if (wr.we_moved)
                moved_reg[ai] <= wr.moved;
        end
    end

    // Out-of-range axes read as zero; the sequencer ignores them anyway.
    assign rd_center = in_range ? center_reg[ai] : '0;
    assign rd_min    = in_range ? min_reg[ai]    : '0;
    assign rd_max    = in_range ? max_reg[ai]    : '0;
    assign rd_conn   = in_range ? conn_reg[ai]   : '0;
    assign rd_moved  = in_range ? moved_reg[ai]  : 1'b0;

endmodule

>>> rtl/core/acal_div.sv
// Bit-serial restoring divider, one quotient bit per clock.
// Expects dividend < divisor; yields dividend * 2^(SAMPLE_BITS-1) / divisor.
module acal_div
    import acal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TW          = SAMPLE_BITS + 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [TW-1:0]          dividend,
    input  logic [TW-1:0]          divisor,
    output logic                   busy,
    output logic                   done,
    output logic [SAMPLE_BITS-2:0] quotient
);

    localparam int CW = $clog2(SAMPLE_BITS);

    logic [TW-1:0]          rem_reg;
    logic [TW-1:0]          dvs_reg;
    logic [SAMPLE_BITS-2:0] quo_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [TW-1:0] shifted;
    logic          ge;

    assign shifted = {rem_reg[TW-2:0], 1'b0};
    assign ge      = (shifted >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= dividend;
            dvs_reg  <= divisor;
            cnt_reg  <= CW'(SAMPLE_BITS - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - dvs_reg) : shifted;
            quo_reg <= {quo_reg[SAMPLE_BITS-3:0], ge};
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/axis_auto_calibration.sv
// Analog stick axis auto-calibration: top level, sequencer and output stage.
// Depends on acal_pkg, acal_cfg, acal_store and acal_div.
//
// Usage: each input transfer on s_axis carries one command (tuser = opcode:
// clear, capture, observe, apply, load) for one axis. Apply and load return
// one result transfer on m_axis; clear, capture, observe and unused opcodes
// return nothing. Settings are written over the APB port; write them only while
// the block is idle, which the block itself does not enforce.
// Timing: one command at a time. Clear, capture and observe only execute; load
// executes and pushes; apply executes, travels, checks, divides and pushes,
// the bit-serial divider resolving one quotient bit per cycle. An apply that
// saturates or gives zero skips divide; one for an axis out of range pushes
// at once. A result appears on m_axis the cycle after the sequencer finishes.
// Stall: results sit in an output register; the next command is accepted
// while a result still waits there, and the sequencer stalls only when a
// second result is ready before the first has been taken.
// Reset: all axis state and the output register clear; the settings return
// to their defaults (automatic mode, rest offset 4096, threshold 3277,
// minimum travel 16384).
module axis_auto_calibration
    import acal_pkg::*;
#(
    parameter int AXIS_COUNT  = AXIS_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_W        = ((3 + 3 * SAMPLE_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((SAMPLE_BITS + 4 + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // axis_index, reading, limit_low, limit_high (low bits first)
    input  logic [IN_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // calibrated_value, axis_out, load_accepted (low bits first)
    output logic [OUT_W-1:0]  m_axis_tdata,
    // is_load_result
    output logic              m_axis_tuser
);

    localparam int SB = SAMPLE_BITS;
    localparam int TW = ((SB > 16) ? SB : 16) + 2;
    localparam logic signed [TW-1:0] ONE_T   = TW'(64'd1 << (SB - 1));
    localparam logic signed [SB-1:0] POS_SAT = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] NEG_SAT = {1'b1, {(SB - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TRAV,
        S_CHK,
        S_DIV,
        S_PUSH
    } state_t;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [2:0]              op_reg, op_next;
    logic [2:0]              idx_reg, idx_next;
    logic signed [SB-1:0]    v_reg, v_next;
    logic signed [SB-1:0]    lo_reg, lo_next;
    logic signed [SB-1:0]    hi_reg, hi_next;
    logic                    neg_reg, neg_next;
    logic signed [TW-1:0]    obs_reg, obs_next;
    logic signed [TW-1:0]    avail_reg, avail_next;
    logic signed [TW-1:0]    mag_reg, mag_next;
    logic                    moved_reg, moved_next;
    logic signed [TW-1:0]    trav_reg, trav_next;
    logic                    zero_reg, zero_next;
    logic signed [SB-1:0]    res_val_reg, res_val_next;
    logic                    res_load_reg, res_load_next;
    logic                    res_acc_reg, res_acc_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [SB-1:0]    m_val_reg, m_val_next;
    logic [2:0]              m_idx_reg, m_idx_next;
    logic                    m_load_reg, m_load_next;
    logic                    m_acc_reg, m_acc_next;

    st_wr_t               wr;
    logic signed [SB-1:0] wr_center, wr_min, wr_max, wr_conn;
    logic signed [SB-1:0] rd_center, rd_min, rd_max, rd_conn;
    logic                 rd_moved;

    logic                 div_start, div_busy, div_done;
    logic [SB-2:0]        quotient;

    logic                 ok;
    logic signed [TW-1:0] v_ext, c_ext, mn_ext, mx_ext, cn_ext;
    logic signed [TW-1:0] mag_v, d_conn, mag_conn, d_center, mag_center;
    logic signed [TW-1:0] rest_ext, thr_ext, mt_ext, floor_t;
    logic                 neg_w;
    logic signed [SB-1:0] widen_min, widen_max;
    logic signed [SB-1:0] q_ext;

    acal_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acal_store #(
        .AXIS_COUNT  (AXIS_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx       (idx_reg),
        .wr        (wr),
        .wr_center (wr_center),
        .wr_min    (wr_min),
        .wr_max    (wr_max),
        .wr_conn   (wr_conn),
        .rd_center (rd_center),
        .rd_min    (rd_min),
        .rd_max    (rd_max),
        .rd_conn   (rd_conn),
        .rd_moved  (rd_moved)
    );

    acal_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TW          (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ($unsigned(mag_reg)),
        .divisor  ($unsigned(trav_reg)),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer terms; samples sign-extend to TW bits, settings zero-extend.
    assign ok         = (32'(idx_reg) < 32'(AXIS_COUNT));
    assign v_ext      = TW'(v_reg);
    assign c_ext      = TW'(rd_center);
    assign mn_ext     = TW'(rd_min);
    assign mx_ext     = TW'(rd_max);
    assign cn_ext     = TW'(rd_conn);
    assign rest_ext   = TW'(cfg.max_rest);
    assign thr_ext    = TW'(cfg.thresh);
    assign mt_ext     = TW'(cfg.min_travel);
    assign mag_v      = (v_ext < 0) ? -v_ext : v_ext;
    assign d_conn     = v_ext - cn_ext;
    assign mag_conn   = (d_conn < 0) ? -d_conn : d_conn;
    assign d_center   = v_ext - c_ext;
    assign mag_center = (d_center < 0) ? -d_center : d_center;
    assign neg_w      = (v_reg < rd_center);
    assign widen_min  = (v_reg < rd_min) ? v_reg : rd_min;
    assign widen_max  = (v_reg > rd_max) ? v_reg : rd_max;
    assign floor_t    = (mt_ext < avail_reg) ? mt_ext : avail_reg;
    assign q_ext      = SB'(quotient);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        v_next        = v_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        neg_next      = neg_reg;
        obs_next      = obs_reg;
        avail_next    = avail_reg;
        mag_next      = mag_reg;
        moved_next    = moved_reg;
        trav_next     = trav_reg;
        zero_next     = zero_reg;
        res_val_next  = res_val_reg;
        res_load_next = res_load_reg;
        res_acc_next  = res_acc_reg;
        m_valid_next  = m_valid_reg;
        m_val_next    = m_val_reg;
        m_idx_next    = m_idx_reg;
        m_load_next   = m_load_reg;
        m_acc_next    = m_acc_reg;
        wr            = '0;
        wr_center     = v_reg;
        wr_min        = widen_min;
        wr_max        = widen_max;
        wr_conn       = v_reg;
        div_start     = 1'b0;

        // Drop the held result once the receiver takes it.
        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    idx_next   = s_axis_tdata[2:0];
                    v_next     = s_axis_tdata[3 +: SB];
                    lo_next    = s_axis_tdata[3 + SB +: SB];
                    hi_next    = s_axis_tdata[3 + 2 * SB +: SB];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next    = S_IDLE;
                res_val_next  = '0;
                res_load_next = 1'b0;
                res_acc_next  = 1'b0;
                case (op_reg)
                    OP_CLEAR:
                        wr.clear = 1'b1;
                    OP_CAPTURE:
                    begin
                        if (ok && !cfg.mode)
                        begin
                            wr.we_center = 1'b1;
                            wr.we_limits = 1'b1;
                            wr.we_conn   = 1'b1;
                            wr.we_moved  = 1'b1;
                            wr.moved     = 1'b0;
                            wr_center    = (mag_v <= rest_ext) ? v_reg : '0;
                            // Seed both limits unless a valid span exists.
                            if (!(rd_min < rd_max))
                            begin
                                wr_min = v_reg;
                                wr_max = v_reg;
                            end
                        end
                    end
                    OP_OBSERVE:
                    begin
                        if (ok && !cfg.mode)
                        begin
                            wr.we_limits = 1'b1;
                            wr.we_moved  = 1'b1;
                            wr.moved     = rd_moved || (mag_conn > thr_ext);
                        end
                    end
                    OP_APPLY:
                    begin
                        if (!ok)
                        begin
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            neg_next   = neg_w;
                            obs_next   = neg_w ? (c_ext - mn_ext) : (mx_ext - c_ext);
                            avail_next = neg_w ? (c_ext + ONE_T) : (ONE_T - c_ext);
                            mag_next   = mag_center;
                            moved_next = rd_moved;
                            state_next = S_TRAV;
                        end
                    end
                    OP_LOAD:
                    begin
                        res_load_next = 1'b1;
                        res_acc_next  = ok && (lo_reg < v_reg) && (v_reg < hi_reg);
                        if (ok && (lo_reg < v_reg) && (v_reg < hi_reg))
                        begin
                            wr.we_center = 1'b1;
                            wr.we_limits = 1'b1;
                            wr_min       = lo_reg;
                            wr_max       = hi_reg;
                        end
                        state_next = S_PUSH;
                    end
                    default:
                        ;
                endcase
            end
            S_TRAV:
            begin
                if (cfg.mode)
                    trav_next = obs_reg;
                else
                    trav_next = (floor_t > obs_reg) ? floor_t : obs_reg;
                zero_next  = !cfg.mode && !moved_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (zero_reg || (trav_reg <= 0))
                begin
                    res_val_next = '0;
                    state_next   = S_PUSH;
                end
                else if (mag_reg >= trav_reg)
                begin
                    // Quotient reaches one or more: saturate.
                    res_val_next = neg_reg ? NEG_SAT : POS_SAT;
                    state_next   = S_PUSH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_val_next = neg_reg ? -q_ext : q_ext;
                    state_next   = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_idx_next   = idx_reg;
                    m_load_next  = res_load_reg;
                    m_acc_next   = res_acc_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            idx_reg      <= '0;
            v_reg        <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            neg_reg      <= 1'b0;
            obs_reg      <= '0;
            avail_reg    <= '0;
            mag_reg      <= '0;
            moved_reg    <= 1'b0;
            trav_reg     <= '0;
            zero_reg     <= 1'b0;
            res_val_reg  <= '0;
            res_load_reg <= 1'b0;
            res_acc_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_val_reg    <= '0;
            m_idx_reg    <= '0;
            m_load_reg   <= 1'b0;
            m_acc_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            idx_reg      <= idx_next;
            v_reg        <= v_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            neg_reg      <= neg_next;
            obs_reg      <= obs_next;
            avail_reg    <= avail_next;
            mag_reg      <= mag_next;
            moved_reg    <= moved_next;
            trav_reg     <= trav_next;
            zero_reg     <= zero_next;
            res_val_reg  <= res_val_next;
            res_load_reg <= res_load_next;
            res_acc_reg  <= res_acc_next;
            m_valid_reg  <= m_valid_next;
            m_val_reg    <= m_val_next;
            m_idx_reg    <= m_idx_next;
            m_load_reg   <= m_load_next;
            m_acc_reg    <= m_acc_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({m_acc_reg, m_idx_reg, m_val_reg});
    assign m_axis_tuser  = m_load_reg;

`ifndef SYNTHESIS
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside the divide step");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transfer taken while a command is in progress");

    a_load_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_load_reg) |-> (m_val_reg == '0))
        else $error("load result carries a nonzero value");

    a_apply_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_load_reg) |-> !m_acc_reg)
        else $error("apply result flagged as accepted load");
`endif

endmodule
